FILE: hw/rtl/fiot_pkg.sv
// ----------------------------------------------------------------------------
// fiot_pkg
// Shared types and codes of the FAT image offset translator.
// ----------------------------------------------------------------------------
package fiot_pkg;

    typedef enum logic [1:0] {
        REQ_FAT_WRITE = 2'd0,
        REQ_MAP_WRITE = 2'd1,
        REQ_TRANSLATE = 2'd2,
        REQ_NONE      = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        MODE_FAT12 = 2'd0,
        MODE_FAT16 = 2'd1,
        MODE_FAT32 = 2'd2,
        MODE_WIDE  = 2'd3
    } fat_mode_t;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_FAT_MODE       = 3'd0;
    localparam logic [2:0] REG_CLUSTER_BYTES  = 3'd1;
    localparam logic [2:0] REG_CLUSTER_COUNT  = 3'd2;
    localparam logic [2:0] REG_DATA_BASE      = 3'd3;
    localparam logic [2:0] REG_MAP_STEP_SHIFT = 3'd4;

    localparam int PADDR_W = 5;

endpackage

FILE: hw/rtl/fat_image_offset_translator.sv
// ----------------------------------------------------------------------------
// fat_image_offset_translator
// Translates file byte offsets on a FAT12/16/32 volume to device addresses.
// ----------------------------------------------------------------------------
// Usage:
//  The request channel (in_valid/in_ready) carries three kinds of request:
//  a FAT byte write, a cluster map entry write, and an offset translation.
//  Writes give no result. A translation gives one result
//  on the output channel (out_valid/out_ready): device_address, or
//  chain_error with a zero address when the chain ends early, an entry
//  falls outside the FAT store, the offset lies beyond the map or the
//  cluster size is zero.
//  The FAT store has one byte-wide read port, so each hop reads its entry
//  one byte a cycle; that port sets the rate. A restart first reads the
//  step's entry from the cluster map. An error reloads the cache from the
//  step's map entry when the slot is in the map and cluster size is nonzero.
//  One request is worked on at a time; in_ready is high only when idle.
//  A finished result waits in the output register while the receiver
//  stalls; write requests are still taken meanwhile, but a further
//  translation holds before its result until the register drains.
//  Reset clears the cached position and cluster and sets the configuration
//  registers to their defaults; both stores are undefined until written,
//  and need no clearing pass. Configuration goes through the APB port,
//  only while the block is idle: the user must keep to this, since the
//  block itself does not enforce it.
// ----------------------------------------------------------------------------
module fat_image_offset_translator
    import fiot_pkg::*;
#(
    parameter int FAT_STORE_BYTES = 65536,
    parameter int MAP_ENTRIES     = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // requests
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [15:0]        fat_byte_addr,
    input  logic [7:0]         fat_byte_value,
    input  logic [8:0]         map_slot,
    input  logic [31:0]        map_cluster_value,
    input  logic [31:0]        file_offset,
    // results
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        device_address,
    output logic               chain_error
);

    localparam int FAW = $clog2(FAT_STORE_BYTES);
    localparam int MAW = $clog2(MAP_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_MAP_RD, S_MAP_CAP, S_CHECK, S_FAT_RD, S_FAT_CAP,
        S_DECODE, S_MUL, S_ADD, S_ERR, S_ERR_RD, S_ERR_CAP, S_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [1:0]  fat_mode_reg;
    logic [16:0] cluster_bytes_reg;
    logic [31:0] cluster_count_reg;
    logic [31:0] data_base_reg;
    logic [4:0]  map_step_shift_reg;

    // cache and working registers
    logic [31:0]    cached_offset_reg, cached_cluster_reg;
    logic [31:0]    pos_reg, posbase_reg, idx_reg;
    logic [31:0]    cp_reg, cl_reg, nx_reg, prod_reg;
    logic [FAW-1:0] fbyte_addr_reg;
    logic [1:0]     byte_cnt_reg;
    logic [31:0]    res_addr_reg;
    logic           res_err_reg;
    logic           out_valid_reg;
    logic [31:0]    out_addr_reg;
    logic           out_err_reg;

    logic cfg_write;
    logic in_fire;
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid & in_ready;

    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_FAT_MODE:       prdata = {30'd0, fat_mode_reg};
            REG_CLUSTER_BYTES:  prdata = {15'd0, cluster_bytes_reg};
            REG_CLUSTER_COUNT:  prdata = cluster_count_reg;
            REG_DATA_BASE:      prdata = data_base_reg;
            REG_MAP_STEP_SHIFT: prdata = {27'd0, map_step_shift_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // stores
    logic [31:0] fat_waddr_ext, map_waddr_ext;
    logic        fat_we, map_we;
    logic [7:0]  fat_rdata;
    logic [31:0] map_rdata;

    assign fat_waddr_ext = {16'd0, fat_byte_addr};
    assign map_waddr_ext = {23'd0, map_slot};
    assign fat_we = in_fire && (req_type == REQ_FAT_WRITE)
                    && (fat_waddr_ext < 32'(FAT_STORE_BYTES));
    assign map_we = in_fire && (req_type == REQ_MAP_WRITE)
                    && (map_waddr_ext < 32'(MAP_ENTRIES));

    fiot_ram #(.WIDTH(8), .DEPTH(FAT_STORE_BYTES)) u_fat_ram (
        .clk   (clk),
        .we    (fat_we),
        .waddr (fat_waddr_ext[FAW-1:0]),
        .wdata (fat_byte_value),
        .raddr (fbyte_addr_reg),
        .rdata (fat_rdata)
    );

    fiot_ram #(.WIDTH(32), .DEPTH(MAP_ENTRIES)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr_ext[MAW-1:0]),
        .wdata (map_cluster_value),
        .raddr (idx_reg[MAW-1:0]),
        .rdata (map_rdata)
    );

    // start-of-translation decisions
    logic [31:0] step_mask, pos_base, pos_idx;
    logic        restart;
    assign step_mask = ~((32'd1 << map_step_shift_reg) - 32'd1);
    assign pos_base  = pos_reg & step_mask;
    assign pos_idx   = pos_reg >> map_step_shift_reg;
    assign restart   = (pos_base != (cached_offset_reg & step_mask))
                       || (pos_reg < cached_offset_reg);

    // walk: is another hop needed, and where does the entry sit
    logic [32:0] cp_end;
    logic        need_hop;
    logic [34:0] ent_addr, ent_last;
    logic        wide_mode;
    assign cp_end    = {1'b0, cp_reg} + {16'd0, cluster_bytes_reg};
    assign need_hop  = cp_end <= {1'b0, pos_reg};
    assign wide_mode = (fat_mode_reg == MODE_FAT32) || (fat_mode_reg == MODE_WIDE);

    always_comb
    begin
        case (fat_mode_reg)
            MODE_FAT12: ent_addr = 35'(({2'd0, cl_reg, 1'b0} + {3'd0, cl_reg}) >> 1);
            MODE_FAT16: ent_addr = {2'd0, cl_reg, 1'b0};
            default:    ent_addr = {1'b0, cl_reg, 2'b00};
        endcase
    end
    assign ent_last = ent_addr + (wide_mode ? 35'd3 : 35'd1);

    // entry decode
    logic [31:0] nx_val;
    always_comb
    begin
        case (fat_mode_reg)
            MODE_FAT12: nx_val = cl_reg[0] ? {20'd0, nx_reg[31:20]}
                                           : {20'd0, nx_reg[27:16]};
            MODE_FAT16: nx_val = {16'd0, nx_reg[31:16]};
            default:    nx_val = nx_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_fire && req_type == REQ_TRANSLATE) state_next = S_START;
            S_START:
                if (cluster_bytes_reg == 17'd0)
                    state_next = S_ERR;
                else if (restart)
                    state_next = (pos_idx >= 32'(MAP_ENTRIES)) ? S_ERR : S_MAP_RD;
                else
                    state_next = S_CHECK;
            S_MAP_RD:  state_next = S_MAP_CAP;
            S_MAP_CAP: state_next = S_CHECK;
            S_CHECK:
                if (!need_hop)
                    state_next = S_MUL;
                else if (ent_last >= 35'(FAT_STORE_BYTES))
                    state_next = S_ERR;
                else
                    state_next = S_FAT_RD;
            S_FAT_RD:  state_next = S_FAT_CAP;
            S_FAT_CAP:
                if (byte_cnt_reg == (wide_mode ? 2'd3 : 2'd1)) state_next = S_DECODE;
            S_DECODE:
                if (nx_val >= cluster_count_reg || nx_val == 32'd0)
                    state_next = S_ERR;
                else
                    state_next = S_CHECK;
            S_MUL:     state_next = S_ADD;
            S_ADD:     state_next = S_OUT;
            S_ERR:
                state_next = (cluster_bytes_reg != 17'd0 && idx_reg < 32'(MAP_ENTRIES))
                             ? S_ERR_RD : S_OUT;
            S_ERR_RD:  state_next = S_ERR_CAP;
            S_ERR_CAP: state_next = S_OUT;
            S_OUT:     if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // (cluster - 2) * cluster_bytes, kept modulo 2^32
    logic [31:0] prod_full;
    assign prod_full = (cl_reg - 32'd2) * {15'd0, cluster_bytes_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            fat_mode_reg       <= MODE_FAT12;
            cluster_bytes_reg  <= 17'd512;
            cluster_count_reg  <= 32'd0;
            data_base_reg      <= 32'd0;
            map_step_shift_reg <= 5'd9;
            cached_offset_reg  <= 32'd0;
            cached_cluster_reg <= 32'd0;
            out_valid_reg      <= 1'b0;
            res_err_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (paddr[PADDR_W-1:2])
                    REG_FAT_MODE:       fat_mode_reg       <= pwdata[1:0];
                    REG_CLUSTER_BYTES:  cluster_bytes_reg  <= pwdata[16:0];
                    REG_CLUSTER_COUNT:  cluster_count_reg  <= pwdata;
                    REG_DATA_BASE:      data_base_reg      <= pwdata;
                    REG_MAP_STEP_SHIFT: map_step_shift_reg <= pwdata[4:0];
                    default:            ;
                endcase
            end

            // writing map entry zero restarts the cache
            if (map_we && map_slot == 9'd0)
            begin
                cached_offset_reg  <= 32'd0;
                cached_cluster_reg <= map_cluster_value;
            end

            // load a finished result, or drop the one just taken
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                    if (in_fire)
                        pos_reg <= file_offset;
                S_START:
                begin
                    posbase_reg <= pos_base;
                    idx_reg     <= pos_idx;
                    cp_reg      <= cached_offset_reg;
                    cl_reg      <= cached_cluster_reg;
                end
                S_MAP_CAP:
                begin
                    cp_reg <= posbase_reg;
                    cl_reg <= map_rdata;
                end
                S_CHECK:
                begin
                    fbyte_addr_reg <= ent_addr[FAW-1:0];
                    byte_cnt_reg   <= 2'd0;
                end
                S_FAT_RD:
                    fbyte_addr_reg <= fbyte_addr_reg + FAW'(1);
                S_FAT_CAP:
                begin
                    // shift bytes in from the top, little-endian
                    nx_reg         <= {fat_rdata, nx_reg[31:8]};
                    fbyte_addr_reg <= fbyte_addr_reg + FAW'(1);
                    byte_cnt_reg   <= byte_cnt_reg + 2'd1;
                end
                S_DECODE:
                begin
                    cl_reg <= nx_val;
                    cp_reg <= cp_end[31:0];
                end
                S_MUL:
                begin
                    prod_reg           <= prod_full;
                    cached_offset_reg  <= cp_reg;
                    cached_cluster_reg <= cl_reg;
                end
                S_ADD:
                begin
                    res_addr_reg <= data_base_reg + prod_reg + (pos_reg - cp_reg);
                    res_err_reg  <= 1'b0;
                end
                S_ERR:
                begin
                    res_addr_reg <= 32'd0;
                    res_err_reg  <= 1'b1;
                end
                S_ERR_CAP:
                begin
                    cached_offset_reg  <= posbase_reg;
                    cached_cluster_reg <= map_rdata;
                end
                S_OUT:
                    if (!out_valid_reg || out_ready)
                    begin
                        out_addr_reg  <= res_addr_reg;
                        out_err_reg   <= res_err_reg;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign device_address = out_addr_reg;
    assign chain_error    = out_err_reg;

endmodule

FILE: hw/rtl/fiot_ram.sv
// ----------------------------------------------------------------------------
// fiot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fiot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// FAT image offset translator testbench
// Drives FAT byte, cluster map and translate requests at the request port,
// with the configuration set over APB between phases. Each result is
// compared field by field with the result of a cycle-free predictor.
// ============================================================================
module tb_top;
    import fiot_pkg::*;

    localparam int FAT_BYTES  = 65536;
    localparam int MAP_SLOTS  = 512;
    localparam int HOP_LIMIT  = 40;

    typedef struct {
        logic [31:0] addr;
        logic        err;
    } xlat_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         req_type = REQ_NONE;
    logic [15:0]        fat_byte_addr = '0;
    logic [7:0]         fat_byte_value = '0;
    logic [8:0]         map_slot = '0;
    logic [31:0]        map_cluster_value = '0;
    logic [31:0]        file_offset = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [31:0]        device_address;
    logic               chain_error;

    fat_image_offset_translator dut (.*);

    always #5 clk = ~clk;

    // Mirror of the block: stores with written marks, cache and registers
    logic [7:0]  fat_mem [FAT_BYTES];
    bit          fat_known [FAT_BYTES];
    logic [31:0] map_mem [MAP_SLOTS];
    bit          map_known [MAP_SLOTS];
    logic [31:0] cache_off;
    logic [31:0] cache_cl;
    fat_mode_t   cfg_mode;
    logic [16:0] cfg_cb;
    logic [31:0] cfg_count;
    logic [31:0] cfg_base;
    logic [4:0]  cfg_shift;

    xlat_result_t pending_results[$];
    int          fail_count = 0;
    int          req_count = 0;
    bit          calm = 1'b0;       // no idling on either side
    bit          hold_ask = 1'b0;   // ask the receiver for a long hold-off
    int          hold_left = 0;

    // ------------------------------------------------------------------------
    // Predictor: one FAT link. Flags a read of a byte never written.
    // ------------------------------------------------------------------------
    function automatic void follow_link(input logic [31:0] cl, output logic [31:0] nx,
                                        output bit bad, inout bit unk);
        longint unsigned a;
        int              nbytes;
        nx = '0;
        bad = 1'b0;
        if (cfg_mode == MODE_FAT12) begin
            a = (longint'(cl) * 3) / 2;
            nbytes = 2;
        end
        else if (cfg_mode == MODE_FAT16) begin
            a = longint'(cl) * 2;
            nbytes = 2;
        end
        else begin
            a = longint'(cl) * 4;
            nbytes = 4;
        end
        if (a + nbytes - 1 >= FAT_BYTES) begin
            bad = 1'b1;
            return;
        end
        for (int i = nbytes - 1; i >= 0; i--) begin
            if (!fat_known[a + i])
                unk = 1'b1;
            nx = (nx << 8) | fat_mem[a + i];
        end
        if (cfg_mode == MODE_FAT12)
            nx = cl[0] ? (nx >> 4) : (nx & 32'hfff);
        if (nx >= cfg_count || nx == 0)
        begin
            bad = 1'b1;
            nx = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: translate one offset. With commit clear it only looks ahead,
    // so that the stimulus can drop requests that would read unwritten state.
    // ------------------------------------------------------------------------
    function automatic void predict_address(input logic [31:0] pos, input bit commit,
                                            output xlat_result_t res, output bit unk);
        logic [31:0]     mask, posbase, idx, off, cl, nx;
        longint unsigned cp, cb;
        bit              bad;
        int              hops;
        res.addr = '0;
        res.err = 1'b0;
        unk = 1'b0;
        off = cache_off;
        cl = cache_cl;
        if (cfg_cb == 0) begin
            res.err = 1'b1;
            return;
        end
        mask = (32'd1 << cfg_shift) - 1;
        posbase = pos & ~mask;
        idx = posbase >> cfg_shift;
        if (posbase != (cache_off & ~mask) || pos < cache_off) begin
            if (idx >= MAP_SLOTS) begin
                res.err = 1'b1;
                return;
            end
            if (!map_known[idx])
                unk = 1'b1;
            off = posbase;
            cl = map_mem[idx];
        end
        cp = off;
        cb = cfg_cb;
        hops = 0;
        while (cp + cb <= pos) begin
            cp += cb;
            hops++;
            if (hops > HOP_LIMIT)
                unk = 1'b1;
            if (unk)
                return;
            follow_link(cl, nx, bad, unk);
            if (bad) begin
                res.err = 1'b1;
                // fall back to the start of the step, or keep the old cache
                if (idx < MAP_SLOTS) begin
                    if (!map_known[idx])
                        unk = 1'b1;
                    off = posbase;
                    cl = map_mem[idx];
                end
                else begin
                    off = cache_off;
                    cl = cache_cl;
                end
                break;
            end
            cl = nx;
        end
        if (!res.err)
            res.addr = 32'(longint'(cfg_base) + longint'(32'(cl - 2)) * cb + (pos - cp));
        if (!res.err)
            off = 32'(cp);
        if (commit && !unk) begin
            cache_off = off;
            cache_cl = cl;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: random gaps, then hold valid until accepted.
    // Entered and left just after a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_req(input req_type_t kind, input logic [15:0] fa, input logic [7:0] fv,
                            input logic [8:0] slot, input logic [31:0] mv,
                            input logic [31:0] off);
        bit rdy;
        while (!calm && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        fat_byte_addr <= fa;
        fat_byte_value <= fv;
        map_slot <= slot;
        map_cluster_value <= mv;
        file_offset <= off;
        // in_ready is stable from the falling edge to the next rising edge
        forever begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
            if (rdy)
                break;
        end
        if (kind != REQ_NONE)
            req_count++;
    endtask

    task automatic put_fat_byte(input logic [15:0] a, input logic [7:0] v);
        fat_mem[a] = v;
        fat_known[a] = 1'b1;
        send_req(REQ_FAT_WRITE, a, v, 9'($urandom), $urandom, $urandom);
    endtask

    task automatic put_map(input logic [8:0] slot, input logic [31:0] v);
        map_mem[slot] = v;
        map_known[slot] = 1'b1;
        if (slot == 0) begin
            cache_off = '0;
            cache_cl = v;
        end
        send_req(REQ_MAP_WRITE, 16'($urandom), 8'($urandom), slot, v, $urandom);
    endtask

    // Write one FAT entry in the current width; FAT12 merges with its neighbour
    task automatic put_entry(input logic [31:0] cl, input logic [31:0] v);
        longint unsigned a;
        logic [15:0]     pair;
        if (cfg_mode == MODE_FAT12) begin
            a = (longint'(cl) * 3) / 2;
            if (a + 1 >= FAT_BYTES)
                return;
            pair = {fat_known[a + 1] ? fat_mem[a + 1] : 8'h00,
                    fat_known[a] ? fat_mem[a] : 8'h00};
            pair = cl[0] ? {v[11:0], pair[3:0]} : {pair[15:12], v[11:0]};
            put_fat_byte(16'(a), pair[7:0]);
            put_fat_byte(16'(a + 1), pair[15:8]);
        end
        else if (cfg_mode == MODE_FAT16) begin
            a = longint'(cl) * 2;
            if (a + 1 >= FAT_BYTES)
                return;
            put_fat_byte(16'(a), v[7:0]);
            put_fat_byte(16'(a + 1), v[15:8]);
        end
        else begin
            a = longint'(cl) * 4;
            if (a + 3 >= FAT_BYTES)
                return;
            for (int i = 0; i < 4; i++)
                put_fat_byte(16'(a + i), v[8*i +: 8]);
        end
    endtask

    // Send a translation only if its walk stays on written state
    task automatic try_translate(input logic [31:0] off);
        xlat_result_t res;
        bit           unk;
        predict_address(off, 1'b0, res, unk);
        if (unk)
            return;
        predict_address(off, 1'b1, res, unk);
        pending_results.push_back(res);
        send_req(REQ_TRANSLATE, 16'($urandom), 8'($urandom), 9'($urandom), $urandom, off);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // the last write may still be in flight
        repeat (20) @(posedge clk);
    endtask

    // A setup phase, then an access phase; the caller ends the transfer
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic set_config(input fat_mode_t m, input logic [16:0] cb, input logic [31:0] cnt,
                              input logic [31:0] base, input logic [4:0] sh);
        drain();
        cfg_mode = m;
        cfg_cb = cb;
        cfg_count = cnt;
        cfg_base = base;
        cfg_shift = sh;
        apb_write(REG_FAT_MODE, 32'(m));
        apb_write(REG_CLUSTER_BYTES, 32'(cb));
        apb_write(REG_CLUSTER_COUNT, cnt);
        apb_write(REG_DATA_BASE, base);
        apb_write(REG_MAP_STEP_SHIFT, 32'(sh));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Largest cluster a chain may use so that its entry stays in the store
    function automatic int top_cluster();
        int hi;
        hi = (cfg_mode == MODE_FAT12) ? 4095 : (cfg_mode == MODE_FAT16) ? 32767 : 16383;
        if (cfg_count - 1 < hi)
            hi = cfg_count - 1;
        return hi;
    endfunction

    // Lay down a chain, point a map slot at it and translate into it
    task automatic chain_and_translate(input int len, input int n_xlat);
        logic [31:0] chain [$];
        logic [31:0] endv, maxent;
        longint unsigned step_base;
        int          hi, slot_hi, slot;
        hi = top_cluster();
        if (hi < 3)
            return;
        for (int i = 0; i <= len; i++)
            chain.push_back($urandom_range(hi, 2));
        maxent = (cfg_mode == MODE_FAT12) ? 32'hfff :
                 (cfg_mode == MODE_FAT16) ? 32'hffff : 32'hffff_ffff;
        case ($urandom_range(2))
            0: endv = '0;
            1: endv = (cfg_count <= maxent) ? cfg_count : 32'd0;
            default: endv = (cfg_mode == MODE_FAT16) ? 32'd40000 : 32'd20000;
        endcase
        for (int i = 0; i < len; i++)
            put_entry(chain[i], chain[i + 1]);
        put_entry(chain[len], endv);
        slot_hi = 32'hffff_ffff >> cfg_shift;
        if (slot_hi > MAP_SLOTS - 1)
            slot_hi = MAP_SLOTS - 1;
        slot = ($urandom_range(3) == 0) ? slot_hi : $urandom_range(slot_hi > 7 ? 7 : slot_hi);
        put_map(9'(slot), chain[0]);
        step_base = longint'(slot) << cfg_shift;
        for (int i = 0; i < n_xlat; i++)
            try_translate(32'(step_base + $urandom_range((len + 2) * cfg_cb)));
    endtask

    // ------------------------------------------------------------------------
    // Result checker: sample on the falling edge, where the handshake is stable
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        xlat_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: device_address %h chain_error %b",
                       device_address, chain_error);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (device_address !== want.addr) begin
                    $error("device_address expected %h actual %h", want.addr, device_address);
                    fail_count++;
                end
                if (chain_error !== want.err) begin
                    $error("chain_error expected %b actual %b", want.err, chain_error);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_ask) begin
            hold_ask <= 1'b0;
            hold_left <= 400;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 25);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed;
        xlat_result_t res;
        // straight after reset: cluster 0 at offset 0, no walk
        try_translate(32'd0);
        set_config(MODE_FAT16, 17'd512, 32'hffff_ffff, 32'hffff_ffff, 5'd12);
        put_map(9'd0, 32'd5);
        put_entry(32'd5, 32'd6);
        put_entry(32'd6, 32'd0);
        try_translate(32'd700);
        try_translate(32'd1100);                 // chain end on a zero entry
        put_map(9'd1, 32'd7);
        put_entry(32'd7, 32'd40000);
        try_translate(32'd4096 + 32'd1100);      // next entry lies outside the store
        try_translate(32'hffff_ffff);            // beyond the map
        put_fat_byte(16'hffff, 8'hff);
        put_map(9'd511, 32'hffff_ffff);
        send_req(REQ_NONE, 16'hffff, 8'hff, 9'h1ff, 32'hffff_ffff, 32'hffff_ffff);
        set_config(MODE_FAT12, 17'd0, 32'd4096, 32'd0, 5'd31);
        try_translate(32'h8000_0000);            // zero cluster size
        set_config(MODE_WIDE, 17'd65536, 32'd100, 32'h1234_5678, 5'd31);
        put_map(9'd1, 32'd3);
        put_entry(32'd3, 32'd4);
        put_entry(32'd4, 32'd100);
        try_translate(32'h8001_0010);
        try_translate(32'h8002_0000);
    endtask

    task automatic test_random_phase;
        int lg, sh, n;
        lg = $urandom_range(7) == 0 ? 16 : $urandom_range(11, 9);
        sh = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 31 : lg)
                                      : $urandom_range(lg + 6, lg);
        set_config(fat_mode_t'($urandom_range(3)),
                   ($urandom_range(15) == 0) ? 17'd0 : 17'(1 << lg),
                   ($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom_range(4096, 3),
                   ($urandom_range(5) == 0) ? 32'hffff_ffff : $urandom, 5'(sh));
        n = $urandom_range(6, 3);
        for (int i = 0; i < n; i++) begin
            chain_and_translate($urandom_range(8, 1), $urandom_range(8, 3));
            // noise: stray bytes, ignored requests, offsets anywhere
            case ($urandom_range(3))
                0: put_fat_byte(16'($urandom), 8'($urandom));
                1: send_req(REQ_NONE, 16'($urandom), 8'($urandom), 9'($urandom),
                            $urandom, $urandom);
                2: try_translate($urandom);
                default: ;
            endcase
        end
    endtask

    task automatic test_backpressure;
        set_config(MODE_FAT32, 17'd512, 32'd3000, $urandom, 5'd14);
        hold_ask = 1'b1;
        for (int i = 0; i < 6; i++)
            chain_and_translate(3, 4);
    endtask

    task automatic test_pause_and_burst;
        chain_and_translate(4, 4);
        // pause until everything is back, then run without idling
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        calm = 1'b1;
        for (int i = 0; i < 5; i++)
            chain_and_translate(5, 6);
        calm = 1'b0;
    endtask

    initial begin
        cfg_mode = MODE_FAT12;
        cfg_cb = 17'd512;
        cfg_count = '0;
        cfg_base = '0;
        cfg_shift = 5'd9;
        cache_off = '0;
        cache_cl = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        while (req_count < 1350) begin
            test_random_phase();
            if ($urandom_range(5) == 0)
                test_pause_and_burst();
        end
        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/fiot_pkg.sv
hw/rtl/fiot_ram.sv
hw/rtl/fat_image_offset_translator.sv
tb/sv/tb_top.sv
